@@ rtl/core/vcv_pkg.sv @@
package vcv_pkg;

  localparam int DEF_MAX_KERNEL    = 5;
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_FRACTION_BITS = 14;

  localparam int PIX_W    = 16;
  localparam int ACC_W    = 40;
  localparam int RES_W    = 24;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 10;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_W    = 13;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_KERNEL_ROWS    = 2'd2,
    REG_KERNEL_COLUMNS = 2'd3
  } vcv_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_COEF  = 1'b1
  } vcv_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } vcv_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } vcv_tap_t;

endpackage

@@ rtl/core/vcv_line_mem.sv @@
module vcv_line_mem #(
  parameter int DEPTH = 5120,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [vcv_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic signed [vcv_pkg::PIX_W-1:0] rdata
);
  import vcv_pkg::*;

  logic signed [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/vcv_mac.sv @@
module vcv_mac #(
  parameter int FRACTION_BITS = vcv_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vcv_pkg::vcv_tap_t                 tap,
  input  logic signed [vcv_pkg::PIX_W-1:0]  pixel,
  input  logic signed [vcv_pkg::PIX_W-1:0]  coef,
  output logic                              done,
  output logic signed [vcv_pkg::RES_W-1:0]  result,
  output logic                              sat
);
  import vcv_pkg::*;

  localparam logic signed [ACC_W:0] HALF =
    (FRACTION_BITS > 0) ? ((ACC_W+1)'(1) <<< ((FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0))
                        : '0;
  localparam logic signed [ACC_W:0] OUT_MAX = (ACC_W+1)'(8388607);
  localparam logic signed [ACC_W:0] OUT_MIN = -(ACC_W+1)'(8388608);

  logic signed [2*PIX_W-1:0] prod_r;
  vcv_tap_t                  tap1_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;
  logic signed [ACC_W:0]     rounded;
  logic signed [ACC_W:0]     shifted;

  always_ff @(posedge clk) begin
    prod_r <= pixel * coef;
    if (tap1_r.valid) begin
      acc_r <= tap1_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap1_r <= '0;
      done_r <= 1'b0;
    end else begin
      tap1_r <= tap;
      done_r <= tap1_r.valid && tap1_r.last;
    end
  end

  always_comb begin
    rounded = (ACC_W+1)'(acc_r) + HALF;
    shifted = rounded >>> FRACTION_BITS;
    sat     = 1'b0;
    result  = RES_W'(shifted);
    if (shifted > OUT_MAX) begin
      result = RES_W'(OUT_MAX);
      sat    = 1'b1;
    end else if (shifted < OUT_MIN) begin
      result = RES_W'(OUT_MIN);
      sat    = 1'b1;
    end
  end

  assign done = done_r;

endmodule

@@ rtl/core/valid_window_2d_convolution.sv @@
// valid-window 2-d convolution over a raster pixel stream
// in_*: stream of items, tuser selects pixel (0) or coefficient write (1);
//   pixels come in raster order, one frame after the other
// out_*: one result per pixel that completes a kernel window inside the
//   image, tlast on the result at the last pixel of the frame
// cfg_*: write port for width, height, kernel rows and kernel columns;
//   any write restarts the frame at row 0, column 0
// a coefficient write or a pixel with no window leaves in_tready high
// a pixel with a window holds in_tready low through the RUN, WAIT and OUT states
//   until its result is in the output register: the single multiply-accumulate unit
//   runs one tap per cycle off one line store read port
// in_tready stays low while a pixel's taps are being worked
// the result waits in an output register; a stalled receiver holds it and
//   the next item is still taken, but the following result waits for it
// reset clears counters, coefficients (to zero) and geometry to
//   1024 x 1024 with a 3 x 3 kernel; the line store is not cleared
module valid_window_2d_convolution #(
  parameter int MAX_KERNEL    = vcv_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH     = vcv_pkg::DEF_MAX_WIDTH,
  parameter int FRACTION_BITS = vcv_pkg::DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_value, coefficient_index, coefficient_value
  input  logic [39:0] in_tdata,
  // opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // output_row, output_column, filtered_value, saturated
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [vcv_pkg::CFG_W-1:0] cfg_wdata
);
  import vcv_pkg::*;

  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW        = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DEPTH     = MAX_KERNEL * MAX_WIDTH;
  localparam int MAW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int CIW       = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

  vcv_state_t state_r, state_nxt;

  logic [10:0] width_reg_r;
  logic [12:0] height_reg_r;
  logic [2:0]  krows_reg_r, kcols_reg_r;

  logic [CW:0]      w;
  logic [12:0]      h;
  logic [2:0]       kr, kc;

  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_r;
  logic [SW-1:0]    slot_r;

  logic signed [PIX_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [PIX_W-1:0] coef_rd_r;

  logic [2:0]       ti_r, tj_r, kr_r, kc_r;
  logic [CIW-1:0]   tk_r;
  logic [SW-1:0]    tslot_r;
  logic [CW-1:0]    left_r;
  vcv_tap_t         iss_r;

  logic [ROW_W-1:0]  orow_r;
  logic [OCOL_W-1:0] ocol_r;
  logic              olast_r;

  logic                    out_valid_r;
  logic [47:0]             out_data_r;
  logic                    out_last_r;

  logic              in_xfer, pix_xfer, coef_xfer;
  logic [ROW_W-1:0]  r_eff;
  logic [CW-1:0]     c_eff;
  logic [SW-1:0]     s_eff;
  logic              win;
  logic              tap_last;
  logic              mem_we;
  logic [MAW-1:0]    mem_waddr, mem_raddr;
  logic signed [PIX_W-1:0] mem_rdata;
  logic signed [PIX_W-1:0] pix_in, coef_in;
  logic [4:0]        cidx_in;
  logic              mac_done, mac_sat;
  logic signed [RES_W-1:0] mac_result;

  assign pix_in  = in_tdata[15:0];
  assign cidx_in = in_tdata[20:16];
  assign coef_in = in_tdata[36:21];

  always_comb begin
    w  = (width_reg_r == 11'd0) ? (CW+1)'(1)
       : (int'(width_reg_r) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(width_reg_r);
    h  = (height_reg_r == 13'd0) ? 13'd1
       : (int'(height_reg_r) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_reg_r;
    kr = (krows_reg_r == 3'd0) ? 3'd1
       : (int'(krows_reg_r) > MAX_KERNEL) ? 3'(MAX_KERNEL) : krows_reg_r;
    kc = (kcols_reg_r == 3'd0) ? 3'd1
       : (int'(kcols_reg_r) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kcols_reg_r;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign pix_xfer  = in_xfer && (vcv_op_t'(in_tuser) == OP_PIXEL);
  assign coef_xfer = in_xfer && (vcv_op_t'(in_tuser) == OP_COEF);

  always_comb begin
    if ((int'(col_r) >= int'(w)) || (int'(row_r) >= int'(h))) begin
      r_eff = '0;
      c_eff = '0;
      s_eff = '0;
    end else begin
      r_eff = row_r;
      c_eff = col_r;
      s_eff = slot_r;
    end
    win = (int'(r_eff) + 1 >= int'(kr)) && (int'(c_eff) + 1 >= int'(kc));
  end

  assign tap_last  = (ti_r == kr_r - 3'd1) && (tj_r == kc_r - 3'd1);
  assign mem_we    = pix_xfer;
  assign mem_waddr = MAW'(int'(s_eff) * MAX_WIDTH + int'(c_eff));
  assign mem_raddr = MAW'(int'(tslot_r) * MAX_WIDTH + int'(left_r) + int'(tj_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pix_xfer && win) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= 11'd1024;
      height_reg_r <= 13'd1024;
      krows_reg_r  <= 3'd3;
      kcols_reg_r  <= 3'd3;
      row_r        <= '0;
      col_r        <= '0;
      slot_r       <= '0;
    end else if (cfg_we) begin
      case (vcv_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:    width_reg_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT:   height_reg_r <= cfg_wdata;
        REG_KERNEL_ROWS:    krows_reg_r  <= cfg_wdata[2:0];
        REG_KERNEL_COLUMNS: kcols_reg_r  <= cfg_wdata[2:0];
        default: ;
      endcase
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (pix_xfer) begin
      if (int'(c_eff) + 1 >= int'(w)) begin
        col_r <= '0;
        if (int'(r_eff) + 1 >= int'(h)) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= r_eff + ROW_W'(1);
          slot_r <= (int'(s_eff) + 1 >= MAX_KERNEL) ? '0 : s_eff + SW'(1);
        end
      end else begin
        col_r  <= c_eff + CW'(1);
        row_r  <= r_eff;
        slot_r <= s_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < COEF_DEPTH; n++) begin
        coef_mem[n] <= '0;
      end
    end else if (coef_xfer && (int'(cidx_in) < COEF_DEPTH)) begin
      coef_mem[CIW'(cidx_in)] <= coef_in;
    end
  end

  // tap sequencer
  always_ff @(posedge clk) begin
    coef_rd_r <= coef_mem[tk_r];
    if (pix_xfer && win) begin
      ti_r    <= '0;
      tj_r    <= '0;
      tk_r    <= '0;
      kr_r    <= kr;
      kc_r    <= kc;
      left_r  <= CW'(int'(c_eff) + 1 - int'(kc));
      tslot_r <= SW'((int'(s_eff) + MAX_KERNEL - (int'(kr) - 1)) >= MAX_KERNEL
                 ? int'(s_eff) - (int'(kr) - 1)
                 : int'(s_eff) + MAX_KERNEL - (int'(kr) - 1));
      orow_r  <= ROW_W'(int'(r_eff) + 1 - int'(kr) + (int'(kr) - 1) / 2);
      ocol_r  <= OCOL_W'(int'(c_eff) + 1 - int'(kc) + (int'(kc) - 1) / 2);
      olast_r <= (int'(r_eff) == int'(h) - 1) && (int'(c_eff) == int'(w) - 1);
    end else if (state_r == ST_RUN) begin
      tk_r <= tk_r + CIW'(1);
      if (tj_r == kc_r - 3'd1) begin
        tj_r    <= '0;
        ti_r    <= ti_r + 3'd1;
        tslot_r <= (int'(tslot_r) + 1 >= MAX_KERNEL) ? '0 : tslot_r + SW'(1);
      end else begin
        tj_r <= tj_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
    end else begin
      iss_r.valid <= (state_r == ST_RUN);
      iss_r.first <= (state_r == ST_RUN) && (ti_r == 3'd0) && (tj_r == 3'd0);
      iss_r.last  <= (state_r == ST_RUN) && tap_last;
    end
  end

  vcv_line_mem #(
    .DEPTH (DEPTH),
    .AW    (MAW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (pix_in),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vcv_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tap    (iss_r),
    .pixel  (mem_rdata),
    .coef   (coef_rd_r),
    .done   (mac_done),
    .result (mac_result),
    .sat    (mac_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_data_r <= {1'b0, mac_sat, mac_result, ocol_r, orow_r};
      out_last_r <= olast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import vcv_pkg::*;

  typedef struct packed {
    logic       opcode;
    logic [15:0] pixel;
    logic [4:0]  cidx;
    logic [15:0] cval;
  } item_t;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [23:0] value;
    logic        sat;
    logic        last;
  } conv_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  valid_window_2d_convolution DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  localparam int MAX_KERNEL_T = 5;
  int unsigned g_width, g_height, g_krows, g_kcols;
  logic signed [15:0] rows_buf [MAX_KERNEL_T][1024];
  logic signed [15:0] coefs [25];
  int unsigned cur_row, cur_col;

  item_t pending_items[$];
  conv_res_t expected_results[$];
  int errors = 0;
  longint cycles = 0;
  bit draining = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return v > hi ? hi : v;
  endfunction

  function automatic void write_geometry(vcv_reg_t idx, int unsigned v);
    case (idx)
      REG_IMAGE_WIDTH:    g_width = v & 11'h7ff;
      REG_IMAGE_HEIGHT:   g_height = v & 13'h1fff;
      REG_KERNEL_ROWS:    g_krows = v & 3'h7;
      REG_KERNEL_COLUMNS: g_kcols = v & 3'h7;
      default: ;
    endcase
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic void predict_convolution(item_t it);
    int unsigned w, h, kr, kc, r, c, top, left;
    longint sum, val;
    conv_res_t res;
    w = clampv(g_width, 1024);
    h = clampv(g_height, 4096);
    kr = clampv(g_krows, 5);
    kc = clampv(g_kcols, 5);
    if (it.opcode == OP_COEF) begin
      if (it.cidx < 25) coefs[it.cidx] = it.cval;
      return;
    end
    if (cur_col >= w || cur_row >= h) begin
      cur_col = 0;
      cur_row = 0;
    end
    r = cur_row;
    c = cur_col;
    rows_buf[r % 5][c] = it.pixel;
    if (r + 1 >= kr && c + 1 >= kc) begin
      top = r + 1 - kr;
      left = c + 1 - kc;
      sum = 0;
      for (int i = 0; i < kr; i++)
        for (int j = 0; j < kc; j++)
          sum += longint'(rows_buf[(top + i) % 5][left + j]) * longint'(coefs[i * kc + j]);
      val = (sum + 64'sd8192) >>> 14;
      res.sat = 1'b0;
      if (val > 8388607) begin val = 8388607; res.sat = 1'b1; end
      if (val < -8388608) begin val = -8388608; res.sat = 1'b1; end
      res.row = 12'(top + (kr - 1) / 2);
      res.col = 10'(left + (kc - 1) / 2);
      res.value = val[23:0];
      res.last = (r == h - 1 && c == w - 1);
      expected_results.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_convolution(item_t'({in_tuser, in_tdata[15:0], in_tdata[20:16],
                                     in_tdata[36:21]}));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_t it;
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.opcode;
          in_tdata <= {3'b0, it.cval, it.cidx, it.pixel};
          in_gap = gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        conv_res_t got, exp_r;
        got = {out_tdata[11:0], out_tdata[21:12], out_tdata[45:22], out_tdata[46],
               out_tlast};
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result %h", got));
        end else begin
          exp_r = expected_results.pop_front();
          if (got.row !== exp_r.row)
            report($sformatf("row got %0d exp %0d", got.row, exp_r.row));
          if (got.col !== exp_r.col)
            report($sformatf("column got %0d exp %0d", got.col, exp_r.col));
          if (got.value !== exp_r.value)
            report($sformatf("value got %h exp %h", got.value, exp_r.value));
          if (got.sat !== exp_r.sat)
            report($sformatf("saturated got %b exp %b", got.sat, exp_r.sat));
          if (got.last !== exp_r.last)
            report($sformatf("last got %b exp %b", got.last, exp_r.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = draining ? 0 : gap_len();
      end
    end
    if (cycles > 3_000_000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(vcv_reg_t idx, int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    write_geometry(idx, v);
  endtask

  task automatic push_pixel(logic [15:0] p);
    pending_items.push_back('{OP_PIXEL, p, 5'($urandom), 16'($urandom)});
  endtask

  task automatic push_coef(logic [4:0] i, logic [15:0] v);
    pending_items.push_back('{OP_COEF, 16'($urandom), i, v});
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // frames of up to 80 pixels each with a fresh geometry and kernel
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned kr, int unsigned kc,
                           int unsigned frames);
    int unsigned npix;
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_KERNEL_ROWS, kr);
    set_reg(REG_KERNEL_COLUMNS, kc);
    npix = clampv(w, 1024) * clampv(h, 4096);
    if (npix > 80) npix = 80;
    for (int i = 0; i < 25; i++)
      if ($urandom_range(0, 2) != 0) push_coef(5'(i), 16'($urandom));
    if ($urandom_range(0, 3) == 0) push_coef(5'($urandom_range(25, 31)), 16'($urandom));
    for (int f = 0; f < frames; f++)
      for (int p = 0; p < npix; p++) begin
        push_pixel(rand_pixel());
        if ($urandom_range(0, 30) == 0) push_coef(5'($urandom), 16'($urandom));
      end
    wait_idle();
  endtask

  initial begin
    g_width = 1024; g_height = 1024; g_krows = 3; g_kcols = 3;
    cur_row = 0; cur_col = 0;
    foreach (coefs[i]) coefs[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 image, full-scale kernel, extreme pixels
    set_reg(REG_IMAGE_WIDTH, 3);
    set_reg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) push_coef(5'(i), 16'h7fff);
    push_coef(5'd31, 16'h1234);
    for (int i = 0; i < 9; i++) push_pixel(16'h7fff);
    for (int i = 0; i < 9; i++) push_pixel(16'h8000);
    wait_idle();
    // rounding half up, negative halves
    run_frame(2, 2, 1, 1, 1);
    push_coef(5'd0, 16'h2000);
    push_pixel(16'h0001); push_pixel(16'hffff); push_pixel(16'h0003); push_pixel(16'hfffd);
    wait_idle();
    // kernel larger than image, and out-of-range geometry values
    run_frame(2, 2, 5, 5, 2);
    run_frame(0, 0, 0, 0, 2);
    run_frame(3, 2, 7, 6, 1);
    run_frame(5, 5, 5, 5, 1);
    run_frame(2047, 1, 1, 5, 1);
    run_frame(1024, 1, 1, 1, 1);

    // random geometries, mostly small
    for (int k = 0; k < 5; k++) begin
      int unsigned kr, kc;
      kr = $urandom_range(1, 5);
      kc = $urandom_range(1, 5);
      run_frame($urandom_range(kc, 7), $urandom_range(kr, 6), kr, kc, $urandom_range(1, 2));
    end
    set_reg(REG_IMAGE_HEIGHT, 8191);
    set_reg(REG_KERNEL_ROWS, 2);
    for (int p = 0; p < 12; p++) push_pixel(rand_pixel());
    wait_idle();

    draining = 1'b1;
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
